@@ rtl/power_rail_state_manager_defines.svh @@
// Assertion macros for the power rail state manager.
`ifndef POWER_RAIL_STATE_MANAGER_DEFINES_SVH
`define POWER_RAIL_STATE_MANAGER_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define PRSM_ASSERT_IMPL(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PRSM_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/prsm_pkg.sv @@
`default_nettype none
package prsm_pkg;

  localparam int unsigned NumRails   = 8;
  localparam int unsigned RailBits   = 3;
  localparam int unsigned SampleBits = 12;
  localparam int unsigned CountBits  = 16;

  localparam logic [2:0] OpLoad  = 3'd0;
  localparam logic [2:0] OpSense = 3'd1;
  localparam logic [2:0] OpOn    = 3'd2;
  localparam logic [2:0] OpOff   = 3'd3;
  localparam logic [2:0] OpTick  = 3'd4;
  localparam logic [2:0] OpFault = 3'd5;
  localparam logic [2:0] OpQuery = 3'd6;

  localparam logic [2:0] StOff     = 3'd0;
  localparam logic [2:0] StTurning = 3'd1;
  localparam logic [2:0] StOn      = 3'd2;
  localparam logic [2:0] StFault   = 3'd3;
  localparam logic [2:0] StFailed  = 3'd4;
  localparam logic [2:0] StTimeout = 3'd5;

  localparam logic [1:0] LiveOff   = 2'd0;
  localparam logic [1:0] LiveOn    = 2'd1;
  localparam logic [1:0] LiveFault = 2'd2;

  localparam logic [1:0] MonVolt = 2'd1;
  localparam logic [1:0] MonPg   = 2'd2;

  typedef logic [RailBits-1:0] rail_t;

  // One rail entry as stored in the rail memory.
  typedef struct packed {
    logic [2:0]            state;
    rail_t                 parent;
    logic [1:0]            mode;
    logic [SampleBits-1:0] thresh;
    logic                  good;
    logic [SampleBits-1:0] volt;
    logic [CountBits-1:0]  wait_cnt;
    logic [CountBits-1:0]  poll_cnt;
  } entry_t;

  typedef struct packed {
    logic [2:0]            opcode;
    rail_t                 rail;
    rail_t                 parent_rail;
    logic [1:0]            monitor_mode;
    logic [SampleBits-1:0] min_level;
    logic                  power_good;
    logic [SampleBits-1:0] voltage_sample;
    logic [CountBits-1:0]  delay_ms;
    logic [CountBits-1:0]  timeout_ms;
  } item_t;

  typedef struct packed {
    rail_t                 result_rail;
    logic [2:0]            rail_state;
    logic [1:0]            rail_status;
    logic                  error;
    logic [NumRails-1:0]   enable_mask;
    logic [NumRails-1:0]   event_mask;
    logic [SampleBits-1:0] voltage;
  } result_t;

  function automatic logic [1:0] live_status(input logic en, input entry_t e);
    logic [1:0] s;
    s = LiveOn;
    if (!en) s = LiveOff;
    else if (e.mode == MonVolt && e.volt < e.thresh) s = LiveFault;
    else if (e.mode == MonPg && !e.good) s = LiveFault;
    return s;
  endfunction

endpackage
`default_nettype wire

@@ rtl/prsm_ram.sv @@
`default_nettype none
module prsm_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

@@ rtl/prsm_ctrl.sv @@
`default_nettype none
module prsm_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire prsm_pkg::item_t   item_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output prsm_pkg::result_t      result_o,
  output logic                   we_o,
  output prsm_pkg::rail_t        waddr_o,
  output prsm_pkg::entry_t       wdata_o,
  output prsm_pkg::rail_t        raddr_o,
  input  wire prsm_pkg::entry_t  rdata_i
);
  import prsm_pkg::*;

  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SRead  = 3'd1;
  localparam logic [2:0] SExec  = 3'd2;
  localparam logic [2:0] SPRead = 3'd3;
  localparam logic [2:0] SPExec = 3'd4;
  localparam logic [2:0] SOut   = 3'd5;

  logic [2:0]          st_q, st_d;
  item_t               item_q;
  rail_t               idx_q, idx_d;
  logic [NumRails-1:0] valid_q, valid_d;
  logic [NumRails-1:0] en_q, en_d;
  logic [NumRails-1:0] ev_q, ev_d;
  result_t             res_q, res_d;
  logic                out_valid_q, out_valid_d;

  entry_t e, ne;
  logic   walk;
  logic   last;

  // Entries never written read as reset values (state off, counters and samples zero).
  always_comb begin
    e = rdata_i;
    if (!valid_q[idx_q]) begin
      e.state    = StOff;
      e.good     = 1'b0;
      e.volt     = '0;
      e.wait_cnt = '0;
      e.poll_cnt = '0;
    end
  end

  assign walk = (item_q.opcode == OpTick) || (item_q.opcode == OpFault);
  assign last = (idx_q == rail_t'(NumRails - 1));

  always_comb begin
    st_d        = st_q;
    idx_d       = idx_q;
    valid_d     = valid_q;
    en_d        = en_q;
    ev_d        = ev_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    ne          = e;
    we_o        = 1'b0;
    raddr_o     = idx_q;
    in_ready_o  = (st_q == SIdle) && !out_valid_q;

    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (st_q)
      SIdle: begin
        if (in_valid_i && in_ready_o) begin
          idx_d   = (item_i.opcode == OpTick || item_i.opcode == OpFault) ? '0 : item_i.rail;
          raddr_o = idx_d;
          ev_d    = '0;
          st_d    = SRead;
        end
      end
      SRead: st_d = SExec;
      SExec: begin
        if (walk) begin
          if (item_q.opcode == OpTick && e.state == StTurning) begin
            if (e.wait_cnt != '0) ne.wait_cnt = e.wait_cnt - 1'b1;
            else if (live_status(en_q[idx_q], e) == LiveOn) begin
              ne.state = StOn;  ev_d[idx_q] = 1'b1;
            end else if (e.poll_cnt == '0) begin
              ne.state = StTimeout;  ev_d[idx_q] = 1'b1;
            end else ne.poll_cnt = e.poll_cnt - 1'b1;
          end
          if (item_q.opcode == OpFault && e.state == StOn &&
              live_status(en_q[idx_q], e) == LiveFault) begin
            ne.state = StFault;  en_d[idx_q] = 1'b0;  ev_d[idx_q] = 1'b1;
          end
          we_o = 1'b1;
          valid_d[idx_q] = 1'b1;
          if (last) begin
            res_d = '0;
            res_d.enable_mask = en_d;
            res_d.event_mask  = ev_d;
            out_valid_d = 1'b1;
            st_d = SIdle;
          end else begin
            idx_d   = idx_q + 1'b1;
            raddr_o = idx_d;
            st_d    = SRead;
          end
        end else if (item_q.opcode == OpOn && e.state != StOn) begin
          raddr_o = e.parent;
          st_d    = SPRead;
        end else begin
          unique case (item_q.opcode)
            OpLoad: begin
              ne.parent = item_q.parent_rail;
              ne.mode   = item_q.monitor_mode;
              ne.thresh = item_q.min_level;
              we_o = 1'b1;
            end
            OpSense: begin
              ne.good = item_q.power_good;
              ne.volt = item_q.voltage_sample;
              we_o = 1'b1;
            end
            OpOff: begin
              ne.state = StOff;  ne.wait_cnt = '0;  ne.poll_cnt = '0;
              en_d[idx_q] = 1'b0;
              we_o = 1'b1;
            end
            default: ;
          endcase
          if (we_o) valid_d[idx_q] = 1'b1;
          st_d = SOut;
        end
      end
      SPRead: st_d = SPExec;
      SPExec: begin
        raddr_o = idx_q;
        if (e.parent != idx_q && !en_q[e.parent]) begin
          ne.state = StFailed;
          res_d.error = 1'b1;
        end else begin
          ne.state    = StTurning;
          ne.wait_cnt = item_q.delay_ms;
          ne.poll_cnt = (item_q.timeout_ms == '1) ? item_q.timeout_ms
                                                  : item_q.timeout_ms + 1'b1;
          en_d[idx_q] = 1'b1;
        end
        we_o = 1'b1;
        valid_d[idx_q] = 1'b1;
        st_d = SOut;
      end
      SOut: begin
        res_d.result_rail = item_q.rail;
        res_d.rail_state  = ne.state;
        res_d.rail_status = live_status(en_q[idx_q], ne);
        res_d.enable_mask = en_q;
        res_d.event_mask  = '0;
        res_d.voltage     = (item_q.opcode == OpQuery) ? ne.volt : '0;
        if (item_q.opcode > OpQuery) begin
          res_d.result_rail = '0;
          res_d.rail_state  = StOff;
          res_d.rail_status = LiveOff;
        end
        out_valid_d = 1'b1;
        st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  assign waddr_o = idx_q;
  assign wdata_o = ne;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= SIdle;
      idx_q       <= '0;
      valid_q     <= '0;
      en_q        <= '0;
      ev_q        <= '0;
      out_valid_q <= 1'b0;
      res_q       <= '0;
    end else begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      valid_q     <= valid_d;
      en_q        <= en_d;
      ev_q        <= ev_d;
      out_valid_q <= out_valid_d;
      if (st_q == SIdle && in_valid_i && in_ready_o) res_q <= '0;
      else res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == SIdle && in_valid_i && in_ready_o) item_q <= item_i;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;
endmodule
`default_nettype wire

@@ rtl/power_rail_state_manager.sv @@
// Channel | Dir | tdata                                       | tuser
// s_axis  | in  | opcode,rail,parent,mode,min,pg,volt,dly,tmo | -
// m_axis  | out | rail,state,status,error,en,ev,voltage        | -
// Register ops step SRead, SExec, SOut; power on adds SPRead and SPExec.
// Tick and fault check walk each rail via SRead, SExec on the single read port.
// Reset clears state, enables and valid bits; rails read as off until written.
// A result waits in the output register; no new beat is taken until it leaves.
`default_nettype none
module power_rail_state_manager (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // opcode[2:0] rail[5:3] parent_rail[8:6] monitor_mode[10:9] min_level[22:11]
  // power_good[23] voltage_sample[35:24] delay_ms[51:36] timeout_ms[67:52]
  input  wire logic [71:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // result_rail[2:0] rail_state[5:3] rail_status[7:6] error[8]
  // enable_mask[16:9] event_mask[24:17] voltage[36:25]
  output logic [39:0]      m_axis_tdata
);
  import prsm_pkg::*;

  item_t   item;
  result_t res;
  logic    we;
  rail_t   waddr, raddr;
  entry_t  wdata, rdata, rdata_fix;
  entry_t  pend_q;
  rail_t   pend_addr_q;
  logic    pend_q_v;

  assign item.opcode         = s_axis_tdata[2:0];
  assign item.rail           = s_axis_tdata[5:3];
  assign item.parent_rail    = s_axis_tdata[8:6];
  assign item.monitor_mode   = s_axis_tdata[10:9];
  assign item.min_level      = s_axis_tdata[22:11];
  assign item.power_good     = s_axis_tdata[23];
  assign item.voltage_sample = s_axis_tdata[35:24];
  assign item.delay_ms       = s_axis_tdata[51:36];
  assign item.timeout_ms     = s_axis_tdata[67:52];

  prsm_ram #(.Depth(NumRails), .Width($bits(entry_t))) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Forward a write that lands in the same cycle as the read of that entry.
  logic  raddr_q_v;
  rail_t raddr_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q_v  <= 1'b0;
      raddr_q_v <= 1'b0;
    end else begin
      pend_q_v  <= we && (waddr == raddr);
      raddr_q_v <= 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    pend_q      <= wdata;
    pend_addr_q <= waddr;
    raddr_q     <= raddr;
  end
  assign rdata_fix = (pend_q_v && raddr_q_v && pend_addr_q == raddr_q) ? pend_q : rdata;

  prsm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .item_i      (item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (res),
    .we_o        (we),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata_fix)
  );

  assign m_axis_tdata = {3'b000, res.voltage, res.event_mask, res.enable_mask,
                         res.error, res.rail_status, res.rail_state, res.result_rail};
endmodule
`default_nettype wire

@@ rtl/prsm_checker.sv @@
`default_nettype none
`include "power_rail_state_manager_defines.svh"
module prsm_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  `PRSM_ASSERT_IMPL(no_take_while_full, clk_i, rst_ni, m_axis_tvalid, !s_axis_tready, "input taken while result pending")
  `PRSM_ASSERT_NEXT(no_instant_result, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, !m_axis_tvalid, "result too early")
  `PRSM_ASSERT_NEXT(result_holds, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `PRSM_ASSERT_IMPL(state_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tdata[5:3] <= 3'd5, "bad rail state")
endmodule
bind power_rail_state_manager prsm_checker u_chk (.*);
`default_nettype wire
